@@ rtl/hioc_pkg.sv @@
// types and constants shared by the hard-iron offset calibrator
// no dependencies; compiled first
package hioc_pkg;

	// operation codes of an input item
	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_SAMPLE = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_DURATION    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES = 1'd1;

	// register reset values
	localparam logic [31:0] DURATION_RESET    = 32'd10000;
	localparam logic [15:0] MIN_SAMPLES_RESET = 16'd20;

	// extremes a cleared window starts from
	localparam logic signed [15:0] AXIS_MIN_RESET = 16'sh7FFF;
	localparam logic signed [15:0] AXIS_MAX_RESET = 16'sh8000;

	localparam int SAMPLES_W = 24;
	localparam int AXES      = 3;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] sample_x;
		logic signed [15:0] sample_y;
		logic signed [15:0] sample_z;
		logic               sample_ok;
	} item_t;

	typedef struct packed {
		logic                 success;
		logic signed [15:0]   offset_x;
		logic signed [15:0]   offset_y;
		logic signed [15:0]   offset_z;
		logic [SAMPLES_W-1:0] samples_taken;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [31:0]          value;
	} cfg_t;

	// per-axis tracker control
	typedef struct packed {
		logic clear;
		logic update;
	} axis_ctl_t;

endpackage

@@ rtl/hioc_chan_if.sv @@
// valid/ready channel carrying one payload beat
// payload type is set by the instantiating level
interface hioc_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/hard_iron_offset_calibrator_core.sv @@
// a result is registered in the result register when the beat that closes the window leaves the input register
// throughput: one item per cycle; only a held result with a stalled sink stops intake
// the input register and the result register part the two channels
// reset: asynchronous, active low; window closed, extremes and count cleared,
// saved offsets zero, duration 10000 ticks, minimum samples 20
module hard_iron_offset_calibrator_core #(
	parameter int COUNT_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	hioc_chan_if.sink   item,
	hioc_chan_if.source result,
	hioc_chan_if.sink   cfg
);
	import hioc_pkg::*;

	logic                  valid_s1;
	item_t                 item_s1;
	logic                  out_valid_q;
	result_t               out_data_q;
	logic [31:0]           duration_q;
	logic [15:0]           min_samples_q;
	logic                  advance;
	logic                  has_result;
	result_t               res;
	axis_ctl_t             axis_ctl;
	logic [AXES-1:0][15:0] axis_off;
	item_t                 item_in;
	cfg_t                  cfg_in;

	assign item_in = item.data;
	assign cfg_in  = cfg.data;

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q    <= DURATION_RESET;
			min_samples_q <= MIN_SAMPLES_RESET;
		end else if (cfg.valid) begin
			case (cfg_in.index)
				REG_DURATION:    duration_q    <= cfg_in.value;
				REG_MIN_SAMPLES: min_samples_q <= cfg_in.value[15:0];
				default: ;
			endcase
		end
	end

	// stage 1 moves on unless its result has nowhere to go
	assign advance    = !has_result || !out_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item_in;
		end
	end

	// per-axis trackers
	hioc_axis u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (axis_ctl),
		.sample (item_s1.sample_x),
		.offset (axis_off[0])
	);

	hioc_axis u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (axis_ctl),
		.sample (item_s1.sample_y),
		.offset (axis_off[1])
	);

	hioc_axis u_axis_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (axis_ctl),
		.sample (item_s1.sample_z),
		.offset (axis_off[2])
	);

	hioc_ctrl #(
		.COUNT_BITS (COUNT_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.advance       (advance),
		.item_s1       (item_s1),
		.duration_q    (duration_q),
		.min_samples_q (min_samples_q),
		.axis_off      (axis_off),
		.axis_ctl      (axis_ctl),
		.has_result    (has_result),
		.res           (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance && has_result) begin
			out_data_q <= res;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	// a blocked result beat holds the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && has_result && out_valid_q && !result.ready) |-> !item.ready)
		else $error("input accepted while result beat blocked");

	// a pending result beat is never overwritten by a new one
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |=> (out_valid_q && $stable(out_data_q)))
		else $error("result beat lost under backpressure");

endmodule

@@ rtl/hioc_axis.sv @@
// running minimum and maximum of one axis, and the midpoint offset
// depends on hioc_pkg
module hioc_axis (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hioc_pkg::axis_ctl_t   ctl,
	input  logic signed [15:0]    sample,
	output logic signed [15:0]    offset
);
	import hioc_pkg::*;

	logic signed [15:0] min_q;
	logic signed [15:0] max_q;
	logic signed [16:0] sum;
	logic signed [16:0] adj;

	// extremes update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= AXIS_MIN_RESET;
			max_q <= AXIS_MAX_RESET;
		end else if (ctl.clear) begin
			min_q <= AXIS_MIN_RESET;
			max_q <= AXIS_MAX_RESET;
		end else if (ctl.update) begin
			if (sample < min_q) begin
				min_q <= sample;
			end
			if (sample > max_q) begin
				max_q <= sample;
			end
		end
	end

	// midpoint, rounded toward zero
	always_comb begin
		sum    = {min_q[15], min_q} + {max_q[15], max_q};
		adj    = sum + {16'b0, sum[16]};
		offset = adj[16:1];
	end

	// once a sample is seen the extremes are ordered
	assert property (@(posedge clk) disable iff (!arst_n)
		(min_q <= max_q) || (min_q == AXIS_MIN_RESET && max_q == AXIS_MAX_RESET))
		else $error("axis extremes out of order");

endmodule

@@ rtl/hioc_ctrl.sv @@
// window control: open flag, elapsed ticks, sample count, saved offsets, result
// depends on hioc_pkg
module hioc_ctrl #(
	parameter int COUNT_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid_s1,
	input  logic                             advance,
	input  hioc_pkg::item_t                  item_s1,
	input  logic [31:0]                      duration_q,
	input  logic [15:0]                      min_samples_q,
	input  logic [hioc_pkg::AXES-1:0][15:0]  axis_off,
	output hioc_pkg::axis_ctl_t              axis_ctl,
	output logic                             has_result,
	output hioc_pkg::result_t                res
);
	import hioc_pkg::*;

	localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	logic                        window_open_q;
	logic [31:0]                 elapsed_q;
	logic [COUNT_BITS-1:0]       count_q;
	logic [AXES-1:0][15:0]       saved_q;

	logic                        fire;
	logic                        is_start;
	logic                        is_sample;
	logic                        is_tick;
	logic [31:0]                 elapsed_inc;
	logic [COUNT_BITS-1:0]       count_used;
	logic                        enough;
	logic [AXES-1:0][15:0]       new_off;
	logic [AXES-1:0][15:0]       res_off;
	logic [SAMPLES_W-1:0]        taken;

	// decode of the beat in stage 1
	always_comb begin
		fire        = valid_s1 && advance;
		is_start    = item_s1.op == OP_START;
		is_sample   = window_open_q && item_s1.op == OP_SAMPLE && item_s1.sample_ok;
		is_tick     = window_open_q && item_s1.op == OP_TICK;
		elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
		has_result  = valid_s1 && ((is_start && duration_q == '0)
			|| (is_tick && elapsed_inc >= duration_q));
		count_used  = is_start ? '0 : count_q;
		enough      = CMP_W'(count_used) >= CMP_W'(min_samples_q);
		axis_ctl.clear  = fire && is_start;
		axis_ctl.update = fire && is_sample;
	end

	// a cleared window always has a zero midpoint
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			new_off[a] = is_start ? 16'd0 : axis_off[a];
			res_off[a] = enough ? new_off[a] : saved_q[a];
		end
	end

	// samples_taken saturates at its field width
	generate
		if (COUNT_BITS > SAMPLES_W) begin : g_sat
			assign taken = (|count_used[COUNT_BITS-1:SAMPLES_W]) ? '1
				: count_used[SAMPLES_W-1:0];
		end else begin : g_ext
			assign taken = SAMPLES_W'(count_used);
		end
	endgenerate

	always_comb begin
		res.success       = enough;
		res.offset_x      = res_off[0];
		res.offset_y      = res_off[1];
		res.offset_z      = res_off[2];
		res.samples_taken = taken;
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_open_q <= 1'b0;
			elapsed_q     <= '0;
			count_q       <= '0;
			saved_q       <= '0;
		end else if (fire) begin
			if (is_start) begin
				window_open_q <= !has_result;
				elapsed_q     <= '0;
				count_q       <= '0;
			end else if (is_sample) begin
				if (count_q != '1) begin
					count_q <= count_q + COUNT_BITS'(1);
				end
			end else if (is_tick) begin
				elapsed_q <= elapsed_inc;
				if (has_result) begin
					window_open_q <= 1'b0;
				end
			end
			if (has_result && enough) begin
				saved_q <= new_off;
			end
		end
	end

	// a finished window is closed afterward
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && has_result) |=> !window_open_q)
		else $error("window still open after result");

	// a start without result leaves a fresh open window
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && is_start && !has_result) |=> (window_open_q && elapsed_q == '0 && count_q == '0))
		else $error("start did not open a fresh window");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking bench for the hard-iron offset calibrator core
// depends on hioc_pkg, hioc_chan_if and hard_iron_offset_calibrator_core
module tb_top;
	import hioc_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 8;
	localparam int MAX_REPORTS   = 10;

	typedef enum logic [1:0] {BEAT_ITEM, BEAT_SETTING, BEAT_DRAIN} beat_kind_t;

	typedef struct {
		beat_kind_t kind;
		item_t      item;
		cfg_t       setting;
		int         pace;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n;

	hioc_chan_if #(.T(item_t))   item_ch ();
	hioc_chan_if #(.T(result_t)) result_ch ();
	hioc_chan_if #(.T(cfg_t))    cfg_ch ();

	hard_iron_offset_calibrator_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stimulus waiting to be driven, offsets waiting to come out
	beat_t   pending_beats [$];
	result_t offsets_due [$];
	int      mismatch_count = 0;
	int      pace = 1;
	int      gen_pace = 1;

	// calibrator state as predicted
	logic [31:0]        dur_ticks;
	logic [15:0]        min_count;
	logic               win_open;
	logic [31:0]        elapsed;
	logic signed [15:0] axis_lo [AXES];
	logic signed [15:0] axis_hi [AXES];
	logic [23:0]        sample_cnt;
	logic signed [15:0] saved_off [AXES];
	logic               saved_valid;

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (pace == 0 || r < 60)
			return 0;
		if (r < 93 || pace == 1)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	task automatic clear_extremes();
		int a;
		elapsed = '0;
		sample_cnt = '0;
		for (a = 0; a < AXES; a++) begin
			axis_lo[a] = AXIS_MIN_RESET;
			axis_hi[a] = AXIS_MAX_RESET;
		end
	endtask

	// window end: new offsets (max+min)/2 on success, else saved or zero
	task automatic close_window();
		result_t            r;
		logic signed [15:0] off [AXES];
		int                 a;
		win_open = 1'b0;
		r.success = (sample_cnt >= 24'(min_count));
		for (a = 0; a < AXES; a++) begin
			if (r.success) begin
				off[a] = 16'((int'(axis_hi[a]) + int'(axis_lo[a])) / 2);
				saved_off[a] = off[a];
			end else begin
				off[a] = saved_valid ? saved_off[a] : '0;
			end
		end
		if (r.success)
			saved_valid = 1'b1;
		r.offset_x = off[0];
		r.offset_y = off[1];
		r.offset_z = off[2];
		r.samples_taken = sample_cnt;
		offsets_due.push_back(r);
	endtask

	// one accepted item through the calibration window
	task automatic advance_calibration(input item_t it);
		logic signed [15:0] s [AXES];
		int                 a;
		s[0] = it.sample_x;
		s[1] = it.sample_y;
		s[2] = it.sample_z;
		if (it.op == OP_START) begin
			clear_extremes();
			win_open = 1'b1;
			if (elapsed >= dur_ticks)
				close_window();
		end else if (win_open && it.op == OP_SAMPLE && it.sample_ok) begin
			for (a = 0; a < AXES; a++) begin
				if (s[a] < axis_lo[a])
					axis_lo[a] = s[a];
				if (s[a] > axis_hi[a])
					axis_hi[a] = s[a];
			end
			if (sample_cnt != '1)
				sample_cnt = sample_cnt + 1'b1;
		end else if (win_open && it.op == OP_TICK) begin
			if (elapsed != '1)
				elapsed = elapsed + 1'b1;
			if (elapsed >= dur_ticks)
				close_window();
		end
	endtask

	task automatic apply_setting(input cfg_t c);
		case (c.index)
		REG_DURATION: dur_ticks = c.value;
		REG_MIN_SAMPLES: min_count = c.value[15:0];
		default: ;
		endcase
	endtask

	// queue filling helpers
	task automatic add_item(input logic [1:0] op, input logic signed [15:0] x,
			input logic signed [15:0] y, input logic signed [15:0] z, input logic ok);
		beat_t b;
		b.kind = BEAT_ITEM;
		b.item.op = op;
		b.item.sample_x = x;
		b.item.sample_y = y;
		b.item.sample_z = z;
		b.item.sample_ok = ok;
		b.setting = '0;
		b.pace = gen_pace;
		pending_beats.push_back(b);
	endtask

	// a register write waits until the block has gone quiet
	task automatic add_setting(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		beat_t b;
		b.item = '0;
		b.pace = gen_pace;
		b.kind = BEAT_DRAIN;
		b.setting = '0;
		pending_beats.push_back(b);
		b.kind = BEAT_SETTING;
		b.setting.index = idx;
		b.setting.value = val;
		pending_beats.push_back(b);
	endtask

	function automatic logic signed [15:0] rand_axis();
		case ($urandom_range(0, 9))
		0: return 16'sh7FFF;
		1: return 16'sh8000;
		default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_sample(input logic ok);
		add_item(OP_SAMPLE, rand_axis(), rand_axis(), rand_axis(), ok);
	endtask

	task automatic add_plain(input logic [1:0] op);
		add_item(op, rand_axis(), rand_axis(), rand_axis(), 1'($urandom));
	endtask

	// item and register driver
	always @(posedge clk or negedge arst_n) begin : drive_beats
		logic  item_go;
		logic  cfg_go;
		item_t item_next;
		cfg_t  cfg_next;
		int    gap_left;
		int    settle;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.data <= '0;
			cfg_ch.valid <= 1'b0;
			cfg_ch.data <= '0;
			gap_left = 0;
			settle = 0;
		end else begin
			item_go = item_ch.valid;
			item_next = item_ch.data;
			cfg_go = cfg_ch.valid;
			cfg_next = cfg_ch.data;
			// retire accepted beats
			if (item_ch.valid && item_ch.ready) begin
				advance_calibration(item_ch.data);
				item_go = 1'b0;
				gap_left = pick_gap();
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				apply_setting(cfg_ch.data);
				cfg_go = 1'b0;
				gap_left = pick_gap();
			end
			// launch the next beat
			if (!item_go && !cfg_go && pending_beats.size() > 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					case (pending_beats[0].kind)
					BEAT_ITEM: begin
						item_go = 1'b1;
						item_next = pending_beats[0].item;
						pace = pending_beats[0].pace;
						void'(pending_beats.pop_front());
					end
					BEAT_SETTING: begin
						cfg_go = 1'b1;
						cfg_next = pending_beats[0].setting;
						pace = pending_beats[0].pace;
						void'(pending_beats.pop_front());
					end
					default: begin
						// hold off until all offsets are out and the pipe is empty
						if (offsets_due.size() == 0 && !result_ch.valid) begin
							settle++;
							if (settle >= SETTLE_CYCLES) begin
								settle = 0;
								pace = pending_beats[0].pace;
								void'(pending_beats.pop_front());
							end
						end else begin
							settle = 0;
						end
					end
					endcase
				end
			end
			item_ch.valid <= item_go;
			item_ch.data <= item_next;
			cfg_ch.valid <= cfg_go;
			cfg_ch.data <= cfg_next;
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin : watch_offsets
		result_t want;
		result_t got;
		int      hold_left;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				got = result_ch.data;
				if (offsets_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("unexpected result beat: success=%0d off=%0d/%0d/%0d n=%0d",
							got.success, got.offset_x, got.offset_y, got.offset_z,
							got.samples_taken);
				end else begin
					want = offsets_due.pop_front();
					if (got.success !== want.success || got.offset_x !== want.offset_x ||
							got.offset_y !== want.offset_y || got.offset_z !== want.offset_z ||
							got.samples_taken !== want.samples_taken) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS) begin
							$write("result mismatch: expected success=%0d off=%0d/%0d/%0d n=%0d",
								want.success, want.offset_x, want.offset_y, want.offset_z,
								want.samples_taken);
							$display(", got success=%0d off=%0d/%0d/%0d n=%0d",
								got.success, got.offset_x, got.offset_y, got.offset_z,
								got.samples_taken);
						end
					end
				end
				hold_left = pick_gap();
			end else if (!result_ch.valid && hold_left == 0 && $urandom_range(0, 7) == 0) begin
				hold_left = pick_gap();
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// predicted reset state
	initial begin
		dur_ticks = DURATION_RESET;
		min_count = MIN_SAMPLES_RESET;
		win_open = 1'b0;
		clear_extremes();
		saved_off[0] = '0;
		saved_off[1] = '0;
		saved_off[2] = '0;
		saved_valid = 1'b0;
	end

	// stimulus, then wind-down and verdict
	initial begin : run_stimulus
		int unsigned dur;
		int unsigned ticks;
		int unsigned mins;
		int          counted;
		int          windows;
		int          r;
		arst_n <= 1'b0;

		// closed window: sample, tick and unused op are ignored
		gen_pace = 0;
		add_plain(OP_TICK);
		add_item(OP_SAMPLE, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1);
		add_item(OP_UNUSED, 16'shFFFF, 16'shFFFF, 16'shFFFF, 1'b1);
		// zero duration: start closes at once, failing, then succeeding with no samples
		add_setting(REG_DURATION, 32'd0);
		add_plain(OP_START);
		add_setting(REG_MIN_SAMPLES, 32'd0);
		add_plain(OP_START);
		// widest settings, extreme readings, window cut short by a duration change
		gen_pace = 2;
		add_setting(REG_DURATION, 32'hFFFF_FFFF);
		add_setting(REG_MIN_SAMPLES, 32'h0000_FFFF);
		add_plain(OP_START);
		add_item(OP_SAMPLE, 16'sh7FFF, 16'sh8000, 16'sh0000, 1'b1);
		add_item(OP_SAMPLE, 16'sh8000, 16'sh7FFF, 16'shFFFF, 1'b1);
		add_item(OP_SAMPLE, -16'sd1, 16'sd1, 16'sd12345, 1'b1);
		add_item(OP_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
		add_item(OP_UNUSED, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
		add_plain(OP_TICK);
		add_plain(OP_TICK);
		add_setting(REG_DURATION, 32'd2);
		add_plain(OP_TICK);
		// restart mid-window, then a success with rounding toward zero
		gen_pace = 1;
		add_setting(REG_MIN_SAMPLES, 32'd2);
		add_setting(REG_DURATION, 32'd3);
		add_plain(OP_START);
		add_item(OP_SAMPLE, 16'sd100, -16'sd7, 16'sh7FFF, 1'b1);
		add_plain(OP_START);
		add_item(OP_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
		add_item(OP_SAMPLE, 16'sh7FFF, 16'sh8001, 16'sd1, 1'b1);
		add_item(OP_SAMPLE, -16'sd3, -16'sd3, -16'sd3, 1'b1);
		repeat (3) add_plain(OP_TICK);
		// too few samples: saved offsets come back
		add_plain(OP_START);
		add_sample(1'b1);
		repeat (3) add_plain(OP_TICK);

		// random phases of well-formed windows with noise mixed in
		counted = 0;
		windows = 0;
		while (counted < 600 || windows < 40) begin
			gen_pace = $urandom_range(0, 2);
			dur = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
			r = $urandom_range(0, 9);
			mins = (r == 0) ? 0 : (r == 1) ? 16'hFFFF : $urandom_range(1, 20);
			add_setting(REG_DURATION, dur);
			add_setting(REG_MIN_SAMPLES, mins);
			repeat ($urandom_range(2, 5)) begin
				if ($urandom_range(0, 3) == 0) begin
					add_plain(2'($urandom_range(1, 3)));
					counted++;
				end
				add_plain(OP_START);
				counted++;
				windows++;
				ticks = 0;
				while (ticks < dur) begin
					r = $urandom_range(0, 99);
					if (r < 50) begin
						add_sample(1'b1);
						counted++;
					end else if (r < 85) begin
						add_plain(OP_TICK);
						ticks++;
						counted++;
					end else if (r < 90) begin
						add_plain(OP_UNUSED);
						counted++;
					end else if (r < 95) begin
						add_sample(1'b0);
						counted++;
					end else if (r < 97) begin
						// duration moved while the window is open
						dur = $urandom_range(0, 12);
						add_setting(REG_DURATION, dur);
						if (dur <= ticks) begin
							add_plain(OP_TICK);
							ticks++;
							counted++;
						end
					end else begin
						add_plain(OP_START);
						ticks = 0;
						counted++;
					end
				end
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_beats.size() != 0 || item_ch.valid || cfg_ch.valid)
			@(posedge clk);
		while (offsets_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// watchdog
	initial begin
		#4_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
